// ----- hw/rtl/mrwe_pkg.sv -----
// ---------------------------------------------------------------------------
// mrwe_pkg: shared types and constants for the message ring
// Field widths of the request and result items and the sequencer state type.
// ---------------------------------------------------------------------------
package mrwe_pkg;

  // Request field widths.
  localparam int LEN_W  = 16;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 12;

  // Free-running start and end counters.
  localparam int CNT_W  = 64;

  // Request kinds carried in the operation field.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Sequencer states, one-hot coded.
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_READ   = 9'b000000100,
    S_SPACE  = 9'b000001000,
    S_EVREAD = 9'b000010000,
    S_EVTEST = 9'b000100000,
    S_WRCHAR = 9'b001000000,
    S_WRTERM = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

endpackage

// ----- hw/rtl/mrwe_ram.sv -----
// ---------------------------------------------------------------------------
// mrwe_ram: ring byte storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mrwe_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mrwe_step.sv -----
// ---------------------------------------------------------------------------
// mrwe_step: shared counter step unit
// Advances a free-running counter by one and its ring position with wrap.
// ---------------------------------------------------------------------------
module mrwe_step
  import mrwe_pkg::*;
#(
  parameter int RING_SIZE = 4096,
  parameter int AW        = 12
) (
  input  logic [CNT_W-1:0] cnt,
  input  logic [AW-1:0]    pos,
  output logic [CNT_W-1:0] cnt_inc,
  output logic [AW-1:0]    pos_inc
);

  localparam logic [AW-1:0] LAST_POS = AW'(RING_SIZE - 1);

  // Counter increment and position increment that wraps at the ring size.
  always_comb begin
    cnt_inc = cnt + CNT_W'(1);
    if (pos == LAST_POS) begin
      pos_inc = '0;
    end else begin
      pos_inc = pos + AW'(1);
    end
  end

endmodule

// ----- hw/rtl/message_ring_whole_eviction.sv -----
// ---------------------------------------------------------------------------
// message_ring_whole_eviction: byte ring of zero-terminated messages
// Stores message characters, evicts whole old messages to make room and
// answers single-byte reads, reporting the start and end counters.
// ---------------------------------------------------------------------------
// Steps: a read passes S_READ and S_DONE, a character S_WRCHAR and S_DONE, a
// last character also S_WRTERM, and a character of a rejected message S_DONE alone.
// A first character adds S_SPACE for the space check, then S_EVREAD and S_EVTEST
// for each eviction step. One request is in work at a time; a result stalled at
// the output holds the sequencer until it drains.
// Reset clears the counters and then sweeps the ring to zero.
module message_ring_whole_eviction
  import mrwe_pkg::*;
#(
  parameter int RING_SIZE = 4096
) (
  input  logic         clk,
  input  logic         rst,
  // Request channel.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: msg_len[15:0], msg_char[23:16], read_index[35:24], zero fill.
  input  logic [39:0]  s_axis_tdata,
  // tuser: operation[0], first[1].
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  // Result channel.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: read_data[7:0], start_count[71:8], end_count[135:72].
  output logic [135:0] m_axis_tdata,
  // tuser: dropped[0].
  output logic         m_axis_tuser
);

  localparam int AW = $clog2(RING_SIZE);
  localparam int SW = $clog2(RING_SIZE + 2);
  localparam logic [AW-1:0]    LAST_POS = AW'(RING_SIZE - 1);
  localparam logic [SW-1:0]    RS_SW    = SW'(RING_SIZE);
  localparam logic [16:0]      RS_17    = 17'(RING_SIZE);
  localparam logic [CNT_W-1:0] RS_CNT   = CNT_W'(RING_SIZE);

  state_t state;

  // Counters and positions.
  logic [CNT_W-1:0] start_cnt, end_cnt;
  logic [AW-1:0]    start_pos, end_pos;
  logic [SW-1:0]    space, need;
  logic             rejecting;
  logic [AW-1:0]    clr_idx;

  // Latched request and pending result.
  logic              it_last;
  logic [CHAR_W-1:0] it_char;
  logic              it_rd_ok;
  logic [7:0]        res_data;
  logic              res_dropped;

  // Request field views.
  logic              in_op, in_first;
  logic [LEN_W-1:0]  in_len;
  logic [CHAR_W-1:0] in_char;
  logic [IDX_W-1:0]  in_idx;
  logic              in_reject;
  logic              accept;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Shared step unit.
  logic             stp_sel_start;
  logic [CNT_W-1:0] stp_cnt_in, stp_cnt;
  logic [AW-1:0]    stp_pos_in, stp_pos;

  // Eviction arithmetic.
  logic [CNT_W-1:0] used;
  logic [SW-1:0]    space_init, space_inc;
  logic             evict_stop;

  assign in_op    = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_len   = s_axis_tdata[15:0];
  assign in_char  = s_axis_tdata[23:16];
  assign in_idx   = s_axis_tdata[35:24];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // A first item with an unusable length starts a rejected message.
  assign in_reject = in_first ? ((in_len == '0) || ({1'b0, in_len} >= RS_17)) : rejecting;

  assign used       = end_cnt - start_cnt;
  assign space_init = RS_SW - used[SW-1:0];
  assign space_inc  = space + SW'(1);
  assign evict_stop = (mem_rdata == 8'd0) && (space_inc >= need);

  // The step unit advances the start side while evicting, else the end side.
  assign stp_sel_start = (state == S_EVTEST);
  assign stp_cnt_in    = stp_sel_start ? start_cnt : end_cnt;
  assign stp_pos_in    = stp_sel_start ? start_pos : end_pos;

  mrwe_step #(
    .RING_SIZE (RING_SIZE),
    .AW        (AW)
  ) u_step (
    .cnt     (stp_cnt_in),
    .pos     (stp_pos_in),
    .cnt_inc (stp_cnt),
    .pos_inc (stp_pos)
  );

  // Memory write source follows the state; reads come from the request
  // while idle and from the start position otherwise.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = end_pos;
    mem_wdata = it_char;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = 8'd0;
      end
      S_EVTEST: begin
        mem_we    = !evict_stop;
        mem_waddr = start_pos;
        mem_wdata = 8'd0;
      end
      S_WRCHAR: begin
        mem_we    = 1'b1;
      end
      S_WRTERM: begin
        mem_we    = 1'b1;
        mem_wdata = 8'd0;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  assign mem_raddr = (state == S_IDLE) ? AW'(in_idx) : start_pos;

  mrwe_ram #(
    .DEPTH (RING_SIZE),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      start_cnt     <= '0;
      end_cnt       <= '0;
      start_pos     <= '0;
      end_pos       <= '0;
      rejecting     <= 1'b0;
      clr_idx       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_POS) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            priority if (in_op == OP_READ) begin
              state <= S_READ;
            end else if (in_reject) begin
              rejecting <= !s_axis_tlast;
              state     <= S_DONE;
            end else if (in_first) begin
              rejecting <= 1'b0;
              state     <= S_SPACE;
            end else begin
              state <= S_WRCHAR;
            end
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_SPACE: begin
          // A used count beyond the ring size wraps the free space: no eviction.
          if (used > RS_CNT || space_init >= need) begin
            state <= S_WRCHAR;
          end else begin
            state <= S_EVREAD;
          end
        end
        S_EVREAD: begin
          state <= S_EVTEST;
        end
        S_EVTEST: begin
          start_cnt <= stp_cnt;
          start_pos <= stp_pos;
          if (evict_stop || space_inc > RS_SW) begin
            state <= S_WRCHAR;
          end else begin
            state <= S_EVREAD;
          end
        end
        S_WRCHAR: begin
          end_cnt <= stp_cnt;
          end_pos <= stp_pos;
          state   <= it_last ? S_WRTERM : S_DONE;
        end
        S_WRTERM: begin
          end_cnt <= stp_cnt;
          end_pos <= stp_pos;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Request payload, eviction space and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_last     <= s_axis_tlast;
      it_char     <= in_char;
      it_rd_ok    <= ({5'd0, in_idx} < RS_17);
      need        <= SW'({1'b0, in_len} + 17'd1);
      res_data    <= 8'd0;
      res_dropped <= (in_op == OP_CHAR) && in_reject;
    end
    if (state == S_READ) begin
      res_data <= it_rd_ok ? mem_rdata : 8'd0;
    end
    if (state == S_SPACE) begin
      space <= space_init;
    end else if (state == S_EVTEST) begin
      space <= space_inc;
    end
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {end_cnt, start_cnt, res_data};
      m_axis_tuser <= res_dropped;
    end
  end

  // An accepted request keeps the input closed on the next cycle.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // Eviction never moves the start counter more than one past the end.
  a_start_bound: assert property (@(posedge clk) disable iff (rst)
    (end_cnt + CNT_W'(1)) >= start_cnt)
    else $error("start counter ran past end counter");

  // The free space tracked during a walk stays within the ring size.
  a_space_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVTEST) |-> (space <= RS_SW))
    else $error("eviction space out of range");

  // A result is loaded only when the output register is free or drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result overwritten");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the message ring with whole-message eviction
// A directed table and a long random run of message characters and byte reads
// are driven into the request stream. Typed table rows carry their expected
// result, a local predictor computes the rest; each is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import mrwe_pkg::*;

  localparam int              RING   = 4096;
  localparam logic [CNT_W-1:0] RING_U = 64'd4096;

  // One request item, and one result item in the order of its fields.
  typedef struct packed {
    logic              op;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [CHAR_W-1:0] chr;
    logic [IDX_W-1:0]  idx;
  } request_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [CNT_W-1:0] start_cnt;
    logic [CNT_W-1:0] end_cnt;
    logic             drop;
  } result_t;

  // A row of the directed table; typed rows carry their own expectation.
  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;

  // Predictor state: ring contents, counters and the rejection flag.
  logic [7:0]       ring_copy [RING];
  logic [CNT_W-1:0] start_pred;
  logic [CNT_W-1:0] end_pred;
  bit               reject_pred;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];
  int       items_sent   = 0;
  int       results_seen = 0;
  int       evict_walks  = 0;
  int       errors       = 0;
  bit       tx_quiet     = 1'b0;
  bit       rx_quiet     = 1'b0;
  int       stall_left   = 0;

  message_ring_whole_eviction DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // Store one byte at the end position and advance the end counter.
  function automatic void store_byte(logic [7:0] b);
    ring_copy[end_pred[11:0]] = b;
    end_pred = end_pred + 1;
  endfunction

  // Compute the result of one request and update the predicted ring.
  function automatic result_t ring_predict(request_t r);
    result_t          res;
    logic [CNT_W-1:0] space;
    logic [CNT_W-1:0] need;
    int unsigned      pos;
    bit               stop;
    res = '0;
    if (r.op == OP_READ) begin
      res.data = ring_copy[r.idx];
    end else begin
      if (r.first) begin
        if (r.len == 0 || r.len >= RING) begin
          reject_pred = 1'b1;
        end else begin
          reject_pred = 1'b0;
          // Walk whole old messages off the front until the new one fits.
          need  = r.len + 1;
          space = RING_U - (end_pred - start_pred);
          pos   = 32'(start_pred % RING_U);
          if (space < need) begin
            evict_walks++;
            stop = 1'b0;
            while (!stop && space <= RING_U) begin
              if (pos >= RING) pos = 0;
              space      = space + 1;
              start_pred = start_pred + 1;
              if (ring_copy[pos[11:0]] == 8'h00 && space >= need) begin
                stop = 1'b1;
              end else begin
                ring_copy[pos[11:0]] = 8'h00;
                pos++;
              end
            end
          end
        end
      end
      if (reject_pred) begin
        res.drop = 1'b1;
        if (r.last) reject_pred = 1'b0;
      end else begin
        store_byte(r.chr);
        if (r.last) store_byte(8'h00);
      end
    end
    res.start_cnt = start_pred;
    res.end_cnt   = end_pred;
    return res;
  endfunction

  // Drive one request, wait for its handshake, then record its expectation.
  task automatic push_request(request_t r, bit typed, result_t want);
    int      gap;
    result_t calc;
    if (!tx_quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, r.idx, r.chr, r.len};
    s_axis_tuser  <= {r.first, r.op};
    s_axis_tlast  <= r.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    calc = ring_predict(r);
    pending_results.push_back(typed ? want : calc);
    items_sent++;
  endtask

  // Hold off new requests until every expected result has returned.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // A read request, half of them close behind the end position.
  function automatic request_t read_request();
    request_t r;
    r       = request_t'({$urandom, $urandom});
    r.op    = OP_READ;
    if ($urandom_range(0, 1) == 0) r.idx = 12'(end_pred[11:0] - $urandom_range(1, 8));
    return r;
  endfunction

  // Send a run of message characters, with an occasional read woven in.
  task automatic send_message(int decl, int count, bit with_last);
    request_t r;
    result_t  none;
    int       i;
    none = '0;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) push_request(read_request(), 1'b0, none);
      r       = request_t'({$urandom, $urandom});
      r.op    = OP_CHAR;
      r.first = (i == 0);
      r.last  = with_last && (i == count - 1);
      if (i == 0) r.len = 16'(decl);
      r.chr   = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      push_request(r, 1'b0, none);
    end
  endtask

  // Append a row to the directed table.
  task automatic add_row(bit op, bit fst, bit lst, int len, int chr, int idx,
                         bit typed, int data, longint s, longint e, bit drop);
    dir_row_t row;
    row.req       = '{op: op, first: fst, last: lst, len: len, chr: chr, idx: idx};
    row.typed     = typed;
    row.want      = '{data: data, start_cnt: s, end_cnt: e, drop: drop};
    dir_rows.push_back(row);
  endtask

  // Result monitor and receiver stall generator.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[71:8], m_axis_tdata[135:72], m_axis_tuser};
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (got.data !== want.data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
          errors++;
        end
        if (got.start_cnt !== want.start_cnt) begin
          $display("%0t: start_count expected %0d actual %0d", $time,
                   want.start_cnt, got.start_cnt);
          errors++;
        end
        if (got.end_cnt !== want.end_cnt) begin
          $display("%0t: end_count expected %0d actual %0d", $time,
                   want.end_cnt, got.end_cnt);
          errors++;
        end
        if (got.drop !== want.drop) begin
          $display("%0t: dropped expected %b actual %b", $time, want.drop, got.drop);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Main sequence: reset, directed table, random traffic, quiet tail.
  initial begin
    int       i;
    int       k;
    int       decl;
    int       count;
    bit       paused;
    request_t r;
    result_t  none;
    longint unsigned free_now;

    none        = '0;
    paused      = 1'b0;
    start_pred  = '0;
    end_pred    = '0;
    reject_pred = 1'b0;
    for (i = 0; i < RING; i++) ring_copy[i] = 8'h00;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reads of the cleared ring, then rejected lengths.
    add_row(OP_READ, 0, 0, 0,      8'h00, 0,     1, 8'h00, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 4095,  1, 8'h00, 0, 0, 0);
    add_row(OP_CHAR, 1, 1, 0,      8'h5A, 0,     1, 8'h00, 0, 0, 1);
    add_row(OP_CHAR, 1, 0, 4096,   8'hFF, 0,     1, 8'h00, 0, 0, 1);
    add_row(OP_CHAR, 0, 0, 0,      8'h00, 0,     1, 8'h00, 0, 0, 1);
    add_row(OP_CHAR, 0, 1, 0,      8'h33, 0,     1, 8'h00, 0, 0, 1);
    add_row(OP_CHAR, 1, 1, 65535,  8'h80, 0,     1, 8'h00, 0, 0, 1);
    // Longest legal message, cut short at two characters.
    add_row(OP_CHAR, 1, 0, 4095,   8'h41, 0,     1, 8'h00, 0, 1, 0);
    add_row(OP_CHAR, 0, 1, 0,      8'hFF, 0,     1, 8'h00, 0, 3, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 0,     1, 8'h41, 0, 3, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 1,     1, 8'hFF, 0, 3, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 2,     1, 8'h00, 0, 3, 0);
    // Characters with no opening item, one of them a zero byte.
    add_row(OP_CHAR, 0, 0, 0,      8'h00, 0,     0, 0, 0, 0, 0);
    add_row(OP_CHAR, 0, 1, 0,      8'h7E, 0,     0, 0, 0, 0, 0);
    // A full-size message forces eviction of everything written so far.
    add_row(OP_CHAR, 1, 1, 4095,   8'h55, 0,     0, 0, 0, 0, 0);
    add_row(OP_CHAR, 1, 1, 1,      8'h00, 0,     0, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 6,     0, 0, 0, 0, 0);
    add_row(OP_CHAR, 1, 0, 2,      8'h80, 0,     0, 0, 0, 0, 0);
    add_row(OP_CHAR, 0, 1, 0,      8'h01, 0,     0, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 4095,  0, 0, 0, 0, 0);
    add_row(OP_CHAR, 1, 1, 4095,   8'h01, 0,     0, 0, 0, 0, 0);
    add_row(OP_CHAR, 1, 1, 3,      8'hAA, 0,     0, 0, 0, 0, 0);
    // A read ignores every message field.
    add_row(OP_READ, 1, 1, 65535,  8'hFF, 4095,  0, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0,      8'h00, 9,     0, 0, 0, 0, 0);

    foreach (dir_rows[j]) push_request(dir_rows[j].req, dir_rows[j].typed, dir_rows[j].want);
    drain_results();

    // Random traffic, about 1900 requests in all with the tail.
    while (items_sent < dir_rows.size() + 1750) begin
      if (!paused && items_sent >= 1000) begin
        drain_results();
        paused = 1'b1;
      end
      k        = $urandom_range(0, 99);
      free_now = RING_U - (end_pred - start_pred);
      if (k < 10) begin
        push_request(read_request(), 1'b0, none);
      end else if (k < 15) begin
        // Rejected message: zero length or too long for the ring.
        case ($urandom_range(0, 3))
          0:       decl = 0;
          1:       decl = RING;
          2:       decl = 65535;
          default: decl = $urandom_range(RING, 65535);
        endcase
        send_message(decl, $urandom_range(1, 4), 1'b1);
      end else if (k < 18) begin
        // Stray character with no opening item.
        r       = request_t'({$urandom, $urandom});
        r.op    = OP_CHAR;
        r.first = 1'b0;
        if (free_now >= 3) push_request(r, 1'b0, none);
      end else if (k < 21) begin
        // Large declared length with few characters: deep eviction.
        send_message($urandom_range(64, RING - 1), $urandom_range(1, 3), 1'b1);
      end else if (k < 24) begin
        // More characters than declared, kept inside the ring.
        decl  = $urandom_range(1, 4);
        count = decl + $urandom_range(1, 8);
        if (count + 2 > free_now) count = decl;
        send_message(decl, count, 1'b1);
      end else if (k < 27) begin
        // Message that never gets its final character.
        decl = $urandom_range(2, 6);
        send_message(decl, $urandom_range(1, decl - 1), 1'b0);
      end else begin
        decl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 2);
        send_message(decl, decl, 1'b1);
      end
    end

    // Tail with no idling on either side.
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (i = 0; i < 60; i++) begin
      if ($urandom_range(0, 3) == 0) push_request(read_request(), 1'b0, none);
      else send_message($urandom_range(1, 3), $urandom_range(1, 3), 1'b1);
    end
    drain_results();

    $display("Run covered %0d requests and %0d results, %0d eviction walks,",
             items_sent, results_seen, evict_walks);
    $display("final start count %0d and end count %0d.", start_pred, end_pred);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mrwe_pkg.sv
hw/rtl/mrwe_ram.sv
hw/rtl/mrwe_step.sv
hw/rtl/message_ring_whole_eviction.sv
bench/tb_top.sv
